// ===== hdl/bft_pkg.sv =====
// Package: word types, chain token and status codes for the bigram frequency table.
`timescale 1ns / 1ps

package bft_pkg;

  localparam logic [2:0] STAT_ACCUM   = 3'd0;
  localparam logic [2:0] STAT_INSERT  = 3'd1;
  localparam logic [2:0] STAT_FOUND   = 3'd2;
  localparam logic [2:0] STAT_MISSING = 3'd3;
  localparam logic [2:0] STAT_DROPPED = 3'd4;

  localparam logic [31:0] FREQ_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        mode;
    logic [7:0]  first_char;
    logic [7:0]  second_char;
    logic [15:0] count_in;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  position;
    logic [31:0] frequency_out;
    logic [9:0]  entries_used;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic        mode;
    logic        hit;
    logic        ins;
    logic [15:0] key;
    logic [15:0] add;
    logic [31:0] freq;
  } tok_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

endpackage

// ===== hdl/bft_cell.sv =====
// One table slot: holds a key and its frequency and passes the search token on.
`timescale 1ns / 1ps

module bft_cell #(
  parameter int INDEX = 0,
  parameter int PW    = 9,
  parameter int CW    = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [CW-1:0]  count,
  input  bft_pkg::tok_t  tok_in,
  input  logic [PW-1:0]  pos_in,
  output bft_pkg::tok_t  tok_out,
  output logic [PW-1:0]  pos_out
);

  logic [15:0]   key;
  logic [31:0]   freq;
  logic          used;
  logic          match;
  logic          ins;
  logic [32:0]   sum;
  logic [31:0]   sat;
  bft_pkg::tok_t tok_next;
  logic [PW-1:0] pos_next;

  always_comb begin
    used  = count > CW'(INDEX);
    match = tok_in.valid && !tok_in.hit && used && (key == tok_in.key);
    ins   = tok_in.valid && !tok_in.hit && !tok_in.mode && (count == CW'(INDEX));
    sum   = {1'b0, freq} + {17'b0, tok_in.add};
    sat   = sum[32] ? bft_pkg::FREQ_MAX : sum[31:0];
    tok_next = tok_in;
    pos_next = pos_in;
    if (match) begin
      tok_next.hit  = 1'b1;
      tok_next.freq = tok_in.mode ? freq : sat;
      pos_next      = PW'(INDEX);
    end else if (ins) begin
      tok_next.hit  = 1'b1;
      tok_next.ins  = 1'b1;
      tok_next.freq = {16'b0, tok_in.add};
      pos_next      = PW'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (match && !tok_in.mode) begin
      freq <= sat;
    end else if (ins) begin
      key  <= tok_in.key;
      freq <= {16'b0, tok_in.add};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.mode <= tok_next.mode;
    tok_out.hit  <= tok_next.hit;
    tok_out.ins  <= tok_next.ins;
    tok_out.key  <= tok_next.key;
    tok_out.add  <= tok_next.add;
    tok_out.freq <= tok_next.freq;
    pos_out      <= pos_next;
  end

endmodule

// ===== hdl/bigram_frequency_table_core.sv =====
// Top level: bigram frequency table built as a chain of slot cells.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+------------------------
//  item    | in        | item_valid/item_stall | mode, key chars, count
//  result  | out       | result_valid/result_stall | status, slot, freq, used
//
// An item runs through all CAPACITY cells, one cell per cycle, and its result
// is then registered at the output; the next item is taken at the earliest in
// the cycle in which that result is first shown.
// A new item is taken once the chain is empty and the spare result slot is free,
// also while a finished result waits on result_stall.
// Reset (rst, synchronous) empties the table; slot contents are
// only read below the entry count, so they need no clearing.
`timescale 1ns / 1ps

module bigram_frequency_table_core #(
  parameter int CAPACITY = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  bft_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output bft_pkg::result_t result
);

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  bft_pkg::tok_t    tok [CAPACITY+1];
  logic [PW-1:0]    pos [CAPACITY+1];
  bft_pkg::tok_t    tok_head;
  logic [CW-1:0]    entry_count;
  logic [CW-1:0]    entry_count_next;
  bft_pkg::state_t  state;
  bft_pkg::state_t  state_next;
  logic             accept;
  logic             done;
  logic             take;
  bft_pkg::tok_t    fin_tok;
  bft_pkg::result_t fin;
  bft_pkg::result_t pend;
  logic             pend_valid;

  assign accept = item_valid && !item_stall;
  assign take   = result_valid && !result_stall;
  assign fin_tok = tok[CAPACITY];
  assign done   = fin_tok.valid;

  always_comb begin
    tok_head.valid = accept;
    tok_head.mode  = item.mode;
    tok_head.hit   = 1'b0;
    tok_head.ins   = 1'b0;
    tok_head.key   = {item.first_char, item.second_char};
    tok_head.add   = item.count_in;
    tok_head.freq  = 32'b0;
  end

  assign tok[0] = tok_head;
  assign pos[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bft_cell #(
      .INDEX(i),
      .PW   (PW),
      .CW   (CW)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .count  (entry_count),
      .tok_in (tok[i]),
      .pos_in (pos[i]),
      .tok_out(tok[i+1]),
      .pos_out(pos[i+1])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      bft_pkg::ST_IDLE:   if (accept) state_next = bft_pkg::ST_SEARCH;
      bft_pkg::ST_SEARCH: if (done) state_next = bft_pkg::ST_IDLE;
      default:            state_next = bft_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      bft_pkg::ST_IDLE: item_stall = pend_valid;
      default:          item_stall = 1'b1;
    endcase
  end

  always_comb begin
    entry_count_next = entry_count + CW'(fin_tok.ins);
    if (fin_tok.mode) begin
      fin.status = fin_tok.hit ? bft_pkg::STAT_FOUND : bft_pkg::STAT_MISSING;
    end else if (fin_tok.ins) begin
      fin.status = bft_pkg::STAT_INSERT;
    end else if (fin_tok.hit) begin
      fin.status = bft_pkg::STAT_ACCUM;
    end else begin
      fin.status = bft_pkg::STAT_DROPPED;
    end
    fin.position      = 9'(pos[CAPACITY]);
    fin.frequency_out = fin_tok.freq;
    fin.entries_used  = 10'(entry_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bft_pkg::ST_IDLE;
      entry_count <= '0;
    end else begin
      state <= state_next;
      if (done) begin
        entry_count <= entry_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
    end else if (take || !result_valid) begin
      if (pend_valid) begin
        result       <= pend;
        result_valid <= 1'b1;
        pend_valid   <= 1'b0;
      end else if (done) begin
        result       <= fin;
        result_valid <= 1'b1;
      end else begin
        result_valid <= 1'b0;
      end
    end else if (done) begin
      pend       <= fin;
      pend_valid <= 1'b1;
    end
  end

endmodule

// ===== test/tb_bigram_frequency_table_core.sv =====
// Testbench: bigram frequency table core checked word by word against an in-bench table model.
`timescale 1ns / 1ps

module tb_bigram_frequency_table_core;

  localparam int TABLE_CAP    = 512;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_WORDS = 880;
  localparam int PHASE_LEN    = RANDOM_WORDS / 4;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 2 * TABLE_CAP + 16;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int PROBES       = 18;

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_FIND   = 1'b1;
  localparam logic TYPED       = 1'b1;
  localparam logic PREDICT     = 1'b0;

  typedef struct packed {
    bft_pkg::item_t   word;
    logic             typed;
    bft_pkg::result_t want;
  } probe_t;

  probe_t probes [PROBES] = '{
    {MODE_FIND,   16'h0000, 16'h0000, TYPED, bft_pkg::STAT_MISSING, 9'd0, 32'h0000_0000, 10'd0},
    {MODE_APPEND, 16'h0000, 16'h0000, TYPED, bft_pkg::STAT_INSERT,  9'd0, 32'h0000_0000, 10'd1},
    {MODE_APPEND, 16'hFFFF, 16'hFFFF, TYPED, bft_pkg::STAT_INSERT,  9'd1, 32'h0000_FFFF, 10'd2},
    {MODE_APPEND, 16'h0000, 16'hFFFF, TYPED, bft_pkg::STAT_ACCUM,   9'd0, 32'h0000_FFFF, 10'd2},
    {MODE_FIND,   16'hFFFF, 16'h0000, TYPED, bft_pkg::STAT_FOUND,   9'd1, 32'h0000_FFFF, 10'd2},
    {MODE_APPEND, 16'hFFFF, 16'hFFFF, PREDICT, 54'd0},
    {MODE_APPEND, 16'hFF00, 16'h8000, TYPED, bft_pkg::STAT_INSERT,  9'd2, 32'h0000_8000, 10'd3},
    {MODE_APPEND, 16'h00FF, 16'h0001, TYPED, bft_pkg::STAT_INSERT,  9'd3, 32'h0000_0001, 10'd4},
    {MODE_FIND,   16'h00FF, 16'hFFFF, TYPED, bft_pkg::STAT_FOUND,   9'd3, 32'h0000_0001, 10'd4},
    {MODE_FIND,   16'hFF00, 16'h1234, TYPED, bft_pkg::STAT_FOUND,   9'd2, 32'h0000_8000, 10'd4},
    {MODE_FIND,   16'h5AA5, 16'h0000, TYPED, bft_pkg::STAT_MISSING, 9'd0, 32'h0000_0000, 10'd4},
    {MODE_APPEND, 16'h5AA5, 16'hAAAA, TYPED, bft_pkg::STAT_INSERT,  9'd4, 32'h0000_AAAA, 10'd5},
    {MODE_APPEND, 16'hA55A, 16'h5555, TYPED, bft_pkg::STAT_INSERT,  9'd5, 32'h0000_5555, 10'd6},
    {MODE_APPEND, 16'h5AA5, 16'h5555, TYPED, bft_pkg::STAT_ACCUM,   9'd4, 32'h0000_FFFF, 10'd6},
    {MODE_FIND,   16'h0000, 16'h0000, TYPED, bft_pkg::STAT_FOUND,   9'd0, 32'h0000_FFFF, 10'd6},
    {MODE_FIND,   16'h0100, 16'h0000, TYPED, bft_pkg::STAT_MISSING, 9'd0, 32'h0000_0000, 10'd6},
    {MODE_APPEND, 16'h0001, 16'h0007, TYPED, bft_pkg::STAT_INSERT,  9'd6, 32'h0000_0007, 10'd7},
    {MODE_APPEND, 16'h00FF, 16'h7FFF, PREDICT, 54'd0}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             result_stall = 1'b0;
  bft_pkg::item_t   item_word;
  logic             item_stall;
  logic             result_valid;
  bft_pkg::result_t got_word;

  logic [15:0]      slot_key [TABLE_CAP];
  logic [31:0]      slot_freq [TABLE_CAP];
  int unsigned      slot_used = 0;
  bft_pkg::result_t due [$];

  int   words_in = 0;
  int   outcome_count [5] = '{default: 0};
  int   mismatches = 0;
  int   cycle_count = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  bit   hold_req = 1'b0;
  logic hold_results = 1'b0;

  bigram_frequency_table_core #(.CAPACITY(TABLE_CAP)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (got_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bft_pkg::result_t tally(input bft_pkg::item_t w);
    logic [15:0]      key;
    logic [32:0]      sum;
    int               s;
    bft_pkg::result_t r;
    key = {w.first_char, w.second_char};
    s = -1;
    r = '0;
    for (int i = 0; i < int'(slot_used); i++)
      if (slot_key[i] == key) s = i;
    if (w.mode == MODE_FIND) begin
      if (s >= 0) begin
        r.status = bft_pkg::STAT_FOUND;
        r.position = 9'(s);
        r.frequency_out = slot_freq[s];
      end else begin
        r.status = bft_pkg::STAT_MISSING;
      end
    end else if (s >= 0) begin
      sum = {1'b0, slot_freq[s]} + {17'd0, w.count_in};
      slot_freq[s] = sum[32] ? bft_pkg::FREQ_MAX : sum[31:0];
      r.status = bft_pkg::STAT_ACCUM;
      r.position = 9'(s);
      r.frequency_out = slot_freq[s];
    end else if (slot_used < TABLE_CAP) begin
      slot_key[slot_used] = key;
      slot_freq[slot_used] = {16'd0, w.count_in};
      r.status = bft_pkg::STAT_INSERT;
      r.position = 9'(slot_used);
      r.frequency_out = {16'd0, w.count_in};
      slot_used++;
    end else begin
      r.status = bft_pkg::STAT_DROPPED;
    end
    r.entries_used = 10'(slot_used);
    return r;
  endfunction

  task automatic send_word(input bft_pkg::item_t w, input logic typed,
                           input bft_pkg::result_t want);
    bft_pkg::result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item_word <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = tally(w);
    due.push_back(typed ? want : predicted);
    words_in++;
  endtask

  task automatic check_result(input bft_pkg::result_t got);
    bft_pkg::result_t want;
    if (due.size() == 0) begin
      $error("result word with nothing expected");
      mismatches++;
      return;
    end
    want = due.pop_front();
    if (got.status != want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
    if (got.position != want.position) begin
      $error("position: expected %0d, got %0d", want.position, got.position);
      mismatches++;
    end
    if (got.frequency_out != want.frequency_out) begin
      $error("frequency_out: expected %h, got %h", want.frequency_out, got.frequency_out);
      mismatches++;
    end
    if (got.entries_used != want.entries_used) begin
      $error("entries_used: expected %0d, got %0d", want.entries_used, got.entries_used);
      mismatches++;
    end
    if (got.status <= bft_pkg::STAT_DROPPED) outcome_count[got.status]++;
  endtask

  task automatic main_stream();
    logic [15:0] key;
    logic [15:0] count;
    logic        mode;
    int          reuse_pct;
    for (int r = 0; r < PROBES; r++)
      send_word(probes[r].word, probes[r].typed, probes[r].want);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % PHASE_LEN == 0) begin
        case (i / PHASE_LEN)
          0: begin idle_pct <= 0;  stall_pct <= 0;  end
          1: begin idle_pct <= 52; stall_pct <= 0;  end
          2: begin idle_pct <= 0;  stall_pct <= 52; end
          default: begin idle_pct <= 7; stall_pct <= 7; end
        endcase
      end
      if (i == HOLD_AT) hold_req = 1'b1;
      mode = ($urandom_range(99) < 12) ? MODE_FIND : MODE_APPEND;
      if (mode == MODE_FIND) reuse_pct = 60;
      else reuse_pct = (slot_used < TABLE_CAP) ? 15 : 40;
      if (slot_used > 0 && $urandom_range(99) < reuse_pct)
        key = slot_key[$urandom_range(slot_used - 1)];
      else
        key = 16'($urandom);
      case ($urandom_range(9))
        0: count = 16'h0000;
        1: count = 16'hFFFF;
        default: count = 16'($urandom);
      endcase
      send_word({mode, key, count}, PREDICT, 54'd0);
    end
    item_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) check_result(got_word);
    end
    result_stall <= hold_results || ($urandom_range(99) < stall_pct);
  end

  // hold results off long enough for the input side to back up
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_results <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_results <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[bigram_frequency_table_core] ERROR");
      $finish;
    end
  end

  initial begin
    item_word = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    main_stream();
    while (due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words; table filled to %0d of %0d slots, with a long result hold.",
             words_in, slot_used, TABLE_CAP);
    $display("Outcomes: %0d accumulated, %0d inserted, %0d found, %0d missing, %0d dropped.",
             outcome_count[bft_pkg::STAT_ACCUM], outcome_count[bft_pkg::STAT_INSERT],
             outcome_count[bft_pkg::STAT_FOUND], outcome_count[bft_pkg::STAT_MISSING],
             outcome_count[bft_pkg::STAT_DROPPED]);
    if (mismatches == 0) begin
      $display("[bigram_frequency_table_core] OK");
    end else begin
      $display("[bigram_frequency_table_core] ERROR");
    end
    $finish;
  end

endmodule
